// ===== design/adaptive_mean_threshold_binarizer_defines.svh =====
// assertion macros for the adaptive mean threshold binarizer
// included by the checker only, no other dependencies
`ifndef ADAPTIVE_MEAN_THRESHOLD_BINARIZER_DEFINES_SVH
`define ADAPTIVE_MEAN_THRESHOLD_BINARIZER_DEFINES_SVH

// same-cycle implication
`define AMTB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AMTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/amtb_pkg.sv =====
// shared types and constants for the adaptive mean threshold binarizer
// no dependencies
`default_nettype none
package amtb_pkg;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int MAX_RADIUS_DEF = 15;
   localparam int MAX_RESULTS    = 16;
   localparam int RES_CNT_W      = $clog2(MAX_RESULTS + 1);
   localparam int PIXEL_W        = 10;
   localparam int COLOR_W        = 8;
   localparam int COORD_W        = 10;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 11;
   localparam int RADIUS_IN_W    = 4;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS       = 2'd0,
      CSR_FRAME_WIDTH  = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_PIXEL = 1'b0,
      MODE_DRAIN = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [PIXEL_W-1:0]  intensity;
   } queue_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_ACC,
      ST_PIX_READ,
      ST_PIX_WAIT,
      ST_MUL,
      ST_CMP,
      ST_EMIT
   } back_state_type;
endpackage
`default_nettype wire

// ===== design/amtb_ram.sv =====
// generic single write, single registered read memory
// no dependencies
`default_nettype none
module amtb_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== design/amtb_front.sv =====
// front end: accepts transactions, forms intensity, queues work for the back end
// depends on amtb_pkg
`default_nettype none
module amtb_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_mode,
   input  wire logic [amtb_pkg::COLOR_W-1:0] req_blue,
   input  wire logic [amtb_pkg::COLOR_W-1:0] req_green,
   input  wire logic [amtb_pkg::COLOR_W-1:0] req_red,
   output logic                             q_valid,
   output amtb_pkg::queue_entry_type        q_entry,
   input  wire logic                        q_pop
);
   import amtb_pkg::*;

   queue_entry_type        entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push;
   queue_entry_type        push_entry;

   assign req_stall = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      push_entry.mode      = mode_type'(req_mode);
      push_entry.intensity = PIXEL_W'(req_blue) + PIXEL_W'(req_green) + PIXEL_W'(req_red);
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule
`default_nettype wire

// ===== design/amtb_back.sv =====
// back end: line store, window sum, threshold compare and result register
// depends on amtb_pkg and amtb_ram
`default_nettype none
module amtb_back #(
   parameter int MAX_WIDTH  = amtb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = amtb_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = amtb_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           q_valid,
   input  wire amtb_pkg::queue_entry_type      q_entry,
   output logic                                q_pop,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [amtb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [amtb_pkg::CSR_DATA_W-1:0] csr_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_white,
   output logic      [amtb_pkg::COORD_W-1:0]    rsp_col,
   output logic      [amtb_pkg::COORD_W-1:0]    rsp_row,
   output logic                                rsp_last
);
   import amtb_pkg::*;

   localparam int LINE_SLOTS = 2 * MAX_RADIUS + 1;
   localparam int XW   = $clog2(MAX_WIDTH + 1);
   localparam int YW   = $clog2(MAX_HEIGHT + 1);
   localparam int RW   = $clog2(MAX_RADIUS + 1);
   localparam int CAW  = ((XW > YW) ? ((XW > RW) ? XW : RW) : ((YW > RW) ? YW : RW)) + 2;
   localparam int SLW  = $clog2(LINE_SLOTS);
   localparam int AW   = $clog2(LINE_SLOTS * MAX_WIDTH);
   localparam int CNTW = $clog2(LINE_SLOTS * LINE_SLOTS + 1);
   localparam int SW   = $clog2(LINE_SLOTS * LINE_SLOTS * 765 + 1);
   localparam int PW   = PIXEL_W + CNTW;

   back_state_type        state_ff, state_in;
   logic [RW-1:0]         radius_ff, radius_in;
   logic [XW-1:0]         width_ff, width_in;
   logic [YW-1:0]         height_ff, height_in;
   logic [XW-1:0]         in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [YW-1:0]         in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [SLW-1:0]        in_slot_ff, in_slot_in, out_slot_ff, out_slot_in;
   logic                  recv_ff, recv_in;
   logic [RES_CNT_W-1:0]  n_ff, n_in, lim_ff, lim_in;
   logic [XW-1:0]         x0_ff, x0_in, x1_ff, x1_in, x_ff, x_in;
   logic [YW-1:0]         y0_ff, y0_in, y1_ff, y1_in, y_ff, y_in;
   logic [SLW-1:0]        yslot_ff, yslot_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic [PIXEL_W-1:0]    pix_ff, pix_in;
   logic [CNTW-1:0]       cnt_ff, cnt_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [XW-1:0]         rcol_ff, rcol_in;
   logic [YW-1:0]         rrow_ff, rrow_in;
   logic                  white_ff, white_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_white_ff, rsp_white_in;
   logic [COORD_W-1:0]    rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [PIXEL_W-1:0]    wr_data, rd_data;

   logic [CAW-1:0]        xs, ys, wm1, hm1, rr, ocol, orow;
   logic [XW-1:0]         nx, wx0;
   logic [YW-1:0]         ny, wy0;
   logic [SLW:0]          dslot, y0slot;
   logic                  ready, out_free, load;

   amtb_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (LINE_SLOTS * MAX_WIDTH)
   ) u_lines (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // window bounds and readiness of the next result position
   always_comb begin
      rr   = CAW'(radius_ff);
      ocol = CAW'(out_col_ff);
      orow = CAW'(out_row_ff);
      xs   = ocol + rr;
      ys   = orow + rr;
      wm1  = CAW'(width_ff) - 1'b1;
      hm1  = CAW'(height_ff) - 1'b1;
      nx   = (xs < wm1) ? XW'(xs) : XW'(wm1);
      ny   = (ys < hm1) ? YW'(ys) : YW'(hm1);
      wx0  = (ocol > rr) ? XW'(ocol - rr) : '0;
      wy0  = (orow > rr) ? YW'(orow - rr) : '0;
      dslot  = (SLW+1)'(out_row_ff - wy0);
      y0slot = ((SLW+1)'(out_slot_ff) >= dslot) ?
               (SLW+1)'(out_slot_ff) - dslot :
               (SLW+1)'(out_slot_ff) + (SLW+1)'(LINE_SLOTS) - dslot;
      ready = recv_ff || (ny < in_row_ff) || ((ny == in_row_ff) && (nx < in_col_ff));
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (q_valid) state_in = ST_CHECK;
         ST_CHECK:    state_in = (ready && (n_ff < lim_ff)) ? ST_READ : ST_IDLE;
         ST_READ:     state_in = ST_ACC;
         ST_ACC:      state_in = ((x_ff == x1_ff) && (y_ff == y1_ff)) ? ST_PIX_READ : ST_READ;
         ST_PIX_READ: state_in = ST_PIX_WAIT;
         ST_PIX_WAIT: state_in = ST_MUL;
         ST_MUL:      state_in = ST_CMP;
         ST_CMP:      state_in = ST_EMIT;
         ST_EMIT:     if (out_free) state_in = ST_CHECK;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [XW-1:0]  ecol;
      logic [YW-1:0]  erow;
      logic [SLW-1:0] eslot;
      radius_in = radius_ff;   width_in = width_ff;     height_in = height_ff;
      in_col_in = in_col_ff;   in_row_in = in_row_ff;   in_slot_in = in_slot_ff;
      out_col_in = out_col_ff; out_row_in = out_row_ff; out_slot_in = out_slot_ff;
      recv_in = recv_ff;       n_in = n_ff;             lim_in = lim_ff;
      x0_in = x0_ff; x1_in = x1_ff; x_in = x_ff;
      y0_in = y0_ff; y1_in = y1_ff; y_in = y_ff;
      yslot_in = yslot_ff;     sum_in = sum_ff;         pix_in = pix_ff;
      cnt_in = cnt_ff;         prod_in = prod_ff;       white_in = white_ff;
      rcol_in = rcol_ff;       rrow_in = rrow_ff;
      rsp_white_in = rsp_white_ff; rsp_col_in = rsp_col_ff;
      rsp_row_in = rsp_row_ff;     rsp_last_in = rsp_last_ff;
      q_pop = 1'b0;
      wr_en = 1'b0;
      ecol = recv_ff ? '0 : in_col_ff;
      erow = recv_ff ? '0 : in_row_ff;
      eslot = recv_ff ? '0 : in_slot_ff;
      wr_addr = AW'(32'(eslot) * MAX_WIDTH + 32'(ecol));
      wr_data = q_entry.intensity;
      rd_addr = AW'(32'(yslot_ff) * MAX_WIDTH + 32'(x_ff));
      load = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               n_in  = '0;
               if (q_entry.mode == MODE_DRAIN) begin
                  lim_in = RES_CNT_W'(1);
               end else begin
                  lim_in = RES_CNT_W'(MAX_RESULTS);
                  wr_en  = 1'b1;
                  if (recv_ff) begin
                     out_col_in = '0; out_row_in = '0; out_slot_in = '0;
                     recv_in = 1'b0;
                  end
                  if (CAW'(ecol) + 1'b1 >= CAW'(width_ff)) begin
                     in_col_in = '0;
                     if (CAW'(erow) + 1'b1 >= CAW'(height_ff)) begin
                        in_row_in  = '0;
                        in_slot_in = '0;
                        recv_in    = 1'b1;
                     end else begin
                        in_row_in  = erow + 1'b1;
                        in_slot_in = ((SLW+1)'(eslot) + 1'b1 == (SLW+1)'(LINE_SLOTS)) ?
                                     '0 : eslot + 1'b1;
                     end
                  end else begin
                     in_col_in = ecol + 1'b1;
                     in_row_in = erow;
                     in_slot_in = eslot;
                  end
               end
            end
         end
         ST_CHECK: begin
            x0_in = wx0; x1_in = nx; x_in = wx0;
            y0_in = wy0; y1_in = ny; y_in = wy0;
            yslot_in = SLW'(y0slot);
            sum_in = '0;
         end
         ST_ACC: begin
            sum_in = sum_ff + SW'(rd_data);
            if (x_ff == x1_ff) begin
               x_in = x0_ff;
               y_in = y_ff + 1'b1;
               yslot_in = ((SLW+1)'(yslot_ff) + 1'b1 == (SLW+1)'(LINE_SLOTS)) ?
                          '0 : yslot_ff + 1'b1;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         ST_PIX_READ: begin
            rd_addr = AW'(32'(out_slot_ff) * MAX_WIDTH + 32'(out_col_ff));
         end
         ST_PIX_WAIT: begin
            pix_in = rd_data;
            cnt_in = CNTW'(CAW'(x1_ff - x0_ff) + 1'b1) * CNTW'(CAW'(y1_ff - y0_ff) + 1'b1);
         end
         ST_MUL: begin
            prod_in = PW'(pix_ff) * PW'(cnt_ff);
         end
         ST_CMP: begin
            white_in = (PW'(prod_ff) > PW'(sum_ff));
            rcol_in = out_col_ff;
            rrow_in = out_row_ff;
            n_in = n_ff + 1'b1;
            if (CAW'(out_col_ff) + 1'b1 >= CAW'(width_ff)) begin
               out_col_in = '0;
               if (CAW'(out_row_ff) + 1'b1 >= CAW'(height_ff)) begin
                  out_row_in = '0; out_slot_in = '0;
                  in_col_in = '0; in_row_in = '0; in_slot_in = '0;
                  recv_in = 1'b0;
               end else begin
                  out_row_in = out_row_ff + 1'b1;
                  out_slot_in = ((SLW+1)'(out_slot_ff) + 1'b1 == (SLW+1)'(LINE_SLOTS)) ?
                                '0 : out_slot_ff + 1'b1;
               end
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load = 1'b1;
               rsp_white_in = white_ff;
               rsp_col_in = COORD_W'(rcol_ff);
               rsp_row_in = COORD_W'(rrow_ff);
               rsp_last_in = !(ready && (n_ff < lim_ff));
            end
         end
         default: begin
         end
      endcase

      // writes to the radius, width and height registers restart the frame
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_RADIUS: begin
               radius_in = (32'(csr_data[RADIUS_IN_W-1:0]) > MAX_RADIUS) ?
                           RW'(MAX_RADIUS) : RW'(csr_data[RADIUS_IN_W-1:0]);
            end
            CSR_FRAME_WIDTH: begin
               width_in = (csr_data == '0) ? XW'(1) :
                          ((32'(csr_data) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(csr_data));
            end
            CSR_FRAME_HEIGHT: begin
               height_in = (csr_data == '0) ? YW'(1) :
                           ((32'(csr_data) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(csr_data));
            end
            default: begin
            end
         endcase
         if (csr_index_type'(csr_index) == CSR_RADIUS ||
             csr_index_type'(csr_index) == CSR_FRAME_WIDTH ||
             csr_index_type'(csr_index) == CSR_FRAME_HEIGHT) begin
            in_col_in = '0; in_row_in = '0; in_slot_in = '0;
            out_col_in = '0; out_row_in = '0; out_slot_in = '0;
            recv_in = 1'b0;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= (MAX_RADIUS > 1) ? RW'(1) : RW'(MAX_RADIUS);
         width_ff     <= (MAX_WIDTH > 1024) ? XW'(1024) : XW'(MAX_WIDTH);
         height_ff    <= (MAX_HEIGHT > 1024) ? YW'(1024) : YW'(MAX_HEIGHT);
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_slot_ff   <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
         out_slot_ff  <= '0;
         recv_ff      <= 1'b0;
         n_ff         <= '0;
         lim_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_slot_ff   <= in_slot_in;
         out_col_ff   <= out_col_in;
         out_row_ff   <= out_row_in;
         out_slot_ff  <= out_slot_in;
         recv_ff      <= recv_in;
         n_ff         <= n_in;
         lim_ff       <= lim_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x0_ff <= x0_in; x1_ff <= x1_in; x_ff <= x_in;
      y0_ff <= y0_in; y1_ff <= y1_in; y_ff <= y_in;
      yslot_ff <= yslot_in;
      sum_ff   <= sum_in;
      pix_ff   <= pix_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      white_ff <= white_in;
      rcol_ff  <= rcol_in;
      rrow_ff  <= rrow_in;
      rsp_white_ff <= rsp_white_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_white = rsp_white_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_last  = rsp_last_ff;
endmodule
`default_nettype wire

// ===== design/adaptive_mean_threshold_binarizer.sv =====
// Adaptive mean threshold binarizer: pixels enter in raster order, results leave in raster
// order once their clipped window of half size radius has arrived; mode-1 drain items flush
// at most one pending result each. Items are queued in front (four entries) and handled one at
// a time by the back end. For each result the back end checks readiness, then reads every
// window entry from the line store ((2r+1)^2 entries at most, one read port, registered),
// then multiplies the count, compares and hands the result off, waiting while the result
// port is stalled.
// Depends on amtb_pkg, amtb_front, amtb_back and amtb_ram.
`default_nettype none
module adaptive_mean_threshold_binarizer #(
   parameter int MAX_WIDTH  = amtb_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = amtb_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_RADIUS = amtb_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_mode,
   input  wire logic [amtb_pkg::COLOR_W-1:0]    req_blue,
   input  wire logic [amtb_pkg::COLOR_W-1:0]    req_green,
   input  wire logic [amtb_pkg::COLOR_W-1:0]    req_red,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_white,
   output logic      [amtb_pkg::COORD_W-1:0]    rsp_col,
   output logic      [amtb_pkg::COORD_W-1:0]    rsp_row,
   output logic                                 rsp_last,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [amtb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [amtb_pkg::CSR_DATA_W-1:0] csr_data
);
   import amtb_pkg::*;

   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   amtb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_mode),
      .req_blue  (req_blue),
      .req_green (req_green),
      .req_red   (req_red),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop)
   );

   amtb_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_white (rsp_white),
      .rsp_col   (rsp_col),
      .rsp_row   (rsp_row),
      .rsp_last  (rsp_last)
   );
endmodule
`default_nettype wire

// ===== design/amtb_checker.sv =====
// port-level checks for the adaptive mean threshold binarizer, bound to the top level
// depends on amtb_pkg and adaptive_mean_threshold_binarizer_defines.svh
`default_nettype none
`include "adaptive_mean_threshold_binarizer_defines.svh"
module amtb_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic                         rsp_white,
   input wire logic [amtb_pkg::COORD_W-1:0] rsp_col,
   input wire logic [amtb_pkg::COORD_W-1:0] rsp_row,
   input wire logic                         rsp_last
);
   import amtb_pkg::*;

   // stalled result holds
   `AMTB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_white) && $stable(rsp_col) && $stable(rsp_row) && $stable(rsp_last), "stalled result changed")
   // no result right after reset
   `AMTB_ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_valid, "result valid after reset")
   // a taken transaction is expected to leave the port empty; a result that waited on a stalled port breaks this
   `AMTB_ASSERT_NEXT(a_rsp_gap, clock, reset, rsp_valid && !rsp_stall, !rsp_valid, "back to back results")
endmodule

bind adaptive_mean_threshold_binarizer amtb_checker u_amtb_checker (.*);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for adaptive_mean_threshold_binarizer: directed and random pixel frames,
// checked against an in-bench window mean predictor with random request gaps and result stalls
// depends on amtb_pkg and the binarizer rtl
`default_nettype none
module tb;
   import amtb_pkg::*;

   localparam int SLOTS = 2 * MAX_RADIUS_DEF + 1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic               white;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = 1'b0;
   logic [COLOR_W-1:0]    req_blue = '0;
   logic [COLOR_W-1:0]    req_green = '0;
   logic [COLOR_W-1:0]    req_red = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_white;
   logic [COORD_W-1:0]    rsp_col;
   logic [COORD_W-1:0]    rsp_row;
   logic                  rsp_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_RADIUS;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // predictor state
   logic [PIXEL_W-1:0] line_store [0:SLOTS*MAX_WIDTH_DEF-1];
   int unsigned in_col, in_row, out_col, out_row;
   bit          frame_done;
   int unsigned radius = 1, frame_w = MAX_WIDTH_DEF, frame_h = MAX_HEIGHT_DEF;

   result_type expected_pixels[$];
   int  mismatches = 0;
   int  pixel_count = 0, drain_count = 0, result_count = 0, write_count = 0;
   bit  req_steady = 1'b0, rsp_steady = 1'b0;
   int  stall_left = 0;

   adaptive_mean_threshold_binarizer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_blue(req_blue), .req_green(req_green), .req_red(req_red),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_white(rsp_white),
      .rsp_col(rsp_col), .rsp_row(rsp_row), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned slot(int unsigned r, int unsigned c);
      return (r % SLOTS) * MAX_WIDTH_DEF + (c % MAX_WIDTH_DEF);
   endfunction

   function automatic void restart_frame();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      frame_done = 1'b0;
   endfunction

   function automatic bit window_complete();
      int unsigned nx, ny, got;
      if (out_row >= frame_h) return 1'b0;
      nx = (out_col + radius < frame_w - 1) ? out_col + radius : frame_w - 1;
      ny = (out_row + radius < frame_h - 1) ? out_row + radius : frame_h - 1;
      got = frame_done ? frame_w * frame_h : in_row * frame_w + in_col;
      return ny * frame_w + nx < got;
   endfunction

   function automatic bit above_mean();
      int unsigned x0, y0, x1, y1, total, cnt;
      x0 = (out_col > radius) ? out_col - radius : 0;
      y0 = (out_row > radius) ? out_row - radius : 0;
      x1 = (out_col + radius < frame_w - 1) ? out_col + radius : frame_w - 1;
      y1 = (out_row + radius < frame_h - 1) ? out_row + radius : frame_h - 1;
      total = 0;
      for (int unsigned y = y0; y <= y1; y++)
         for (int unsigned x = x0; x <= x1; x++)
            total += line_store[slot(y, x)];
      cnt = (x1 - x0 + 1) * (y1 - y0 + 1);
      return line_store[slot(out_row, out_col)] > total / cnt;
   endfunction

   function automatic void emit_ready(int limit);
      result_type r;
      int n;
      n = 0;
      while (n < limit && window_complete()) begin
         r.white = above_mean();
         r.col   = out_col[COORD_W-1:0];
         r.row   = out_row[COORD_W-1:0];
         r.last  = 1'b0;
         expected_pixels.push_back(r);
         n++;
         out_col++;
         if (out_col >= frame_w) begin
            out_col = 0;
            out_row++;
            if (out_row >= frame_h) restart_frame();
         end
      end
      if (n > 0) expected_pixels[expected_pixels.size()-1].last = 1'b1;
   endfunction

   function automatic void predict_item(mode_type m, logic [7:0] b, logic [7:0] g,
                                        logic [7:0] r);
      if (m == MODE_DRAIN) begin
         emit_ready(1);
         return;
      end
      if (frame_done) restart_frame();
      line_store[slot(in_row, in_col)] = PIXEL_W'(b) + PIXEL_W'(g) + PIXEL_W'(r);
      in_col++;
      if (in_col >= frame_w) begin
         in_col = 0;
         in_row++;
         if (in_row >= frame_h) begin
            in_row = 0;
            frame_done = 1'b1;
         end
      end
      emit_ready(MAX_RESULTS);
   endfunction

   function automatic void predict_write(logic [CSR_IDX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] d);
      int unsigned v;
      case (idx)
         CSR_RADIUS: begin
            v = d[RADIUS_IN_W-1:0];
            radius = (v > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : v;
         end
         CSR_FRAME_WIDTH, CSR_FRAME_HEIGHT: begin
            v = d;
            if (v == 0) v = 1;
            if (idx == CSR_FRAME_WIDTH) frame_w = (v > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : v;
            else frame_h = (v > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : v;
         end
         default: return;
      endcase
      restart_frame();
   endfunction

   // result side: random stall and per-transaction compare
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result col %0d row %0d", rsp_col, rsp_row);
         end else begin
            result_type e;
            e = expected_pixels.pop_front();
            if (e.white !== rsp_white || e.col !== rsp_col || e.row !== rsp_row ||
                e.last !== rsp_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected white %0b col %0d row %0d last %0b, ",
                            "got %0b %0d %0d %0b"},
                           e.white, e.col, e.row, e.last, rsp_white, rsp_col, rsp_row, rsp_last);
            end
         end
         if (result_count % 25 == 0) rsp_steady = ($urandom_range(0, 3) == 0);
         stall_left = rsp_steady ? 0 : $urandom_range(0, 5);
      end else if (stall_left > 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left > 0);
   end

   task automatic send_item(mode_type m, logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= m;
      req_blue  <= b;
      req_green <= g;
      req_red   <= r;
      do @(posedge clock); while (req_stall);
      predict_item(m, b, g, r);
      if (m == MODE_DRAIN) drain_count++;
      else pixel_count++;
   endtask

   task automatic send_random_pixel();
      send_item(MODE_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      predict_write(idx, d);
      write_count++;
   endtask

   task automatic set_frame(int r, int w, int h);
      write_reg(CSR_RADIUS, CSR_DATA_W'(r));
      write_reg(CSR_FRAME_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_FRAME_HEIGHT, CSR_DATA_W'(h));
   endtask

   task automatic flush_frame();
      while (window_complete()) send_item(MODE_DRAIN, '0, '0, '0);
   endtask

   task automatic test_reset_defaults();
      // full size frame, radius 1: a partial first row gives no results
      for (int i = 0; i < 12; i++)
         send_item(MODE_PIXEL, (i % 2) ? 8'hff : 8'h00, (i % 3) ? 8'hff : 8'h00,
                   (i % 4) ? 8'h00 : 8'hff);
      send_item(MODE_DRAIN, '0, '0, '0);
   endtask

   task automatic test_small_frame();
      set_frame(1, 4, 3);
      send_item(MODE_DRAIN, '0, '0, '0);
      send_item(MODE_PIXEL, 8'hff, 8'hff, 8'hff);
      send_item(MODE_PIXEL, 8'h00, 8'h00, 8'h00);
      send_item(MODE_PIXEL, 8'hff, 8'h00, 8'h00);
      send_item(MODE_PIXEL, 8'h00, 8'hff, 8'h00);
      send_item(MODE_PIXEL, 8'h00, 8'h00, 8'hff);
      send_item(MODE_DRAIN, 8'hff, 8'hff, 8'hff);
      repeat (7) send_random_pixel();
      flush_frame();
      send_item(MODE_DRAIN, '0, '0, '0);
   endtask

   task automatic test_radius_extremes();
      set_frame(0, 3, 2);
      repeat (6) send_random_pixel();
      flush_frame();
      // radius 15 covers the whole frame, more than 16 results become ready at once
      set_frame(15, 5, 4);
      repeat (20) send_random_pixel();
      flush_frame();
      // radius field takes only the low bits
      write_reg(CSR_RADIUS, 11'h7f3);
      repeat (4) send_random_pixel();
   endtask

   task automatic test_size_limits();
      // zero sizes act as one, oversize saturates
      set_frame(2, 0, 0);
      send_item(MODE_PIXEL, 8'h80, 8'h80, 8'h80);
      send_item(MODE_PIXEL, 8'h01, 8'h02, 8'h03);
      flush_frame();
      write_reg(CSR_FRAME_WIDTH, 11'h7ff);
      write_reg(CSR_FRAME_HEIGHT, 11'd2);
      write_reg(CSR_RADIUS, 11'd1);
      repeat (6) send_random_pixel();
      write_reg(CSR_FRAME_HEIGHT, 11'h7ff);
      write_reg(CSR_FRAME_WIDTH, 11'd1024);
      write_reg(CSR_UNUSED, 11'h5a5);
      repeat (3) send_random_pixel();
   endtask

   task automatic test_new_frame_discard();
      set_frame(1, 3, 3);
      repeat (9) send_random_pixel();
      // the next frame starts once every result of the first has left
      repeat (5) send_random_pixel();
      send_item(MODE_DRAIN, '0, '0, '0);
   endtask

   task automatic test_random_frames();
      int budget, w, h, n;
      budget = 60;
      while (budget > 0) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 6);
         h = $urandom_range(1, 6);
         set_frame(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3),
                   w, h);
         req_steady = ($urandom_range(0, 3) == 0);
         n = w * h;
         if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(MODE_DRAIN, 8'($urandom), '0, '0);
            send_random_pixel();
            budget--;
         end
         if ($urandom_range(0, 3) != 0) flush_frame();
      end
      req_steady = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_small_frame();
      test_radius_extremes();
      test_size_limits();
      test_new_frame_discard();
      test_random_frames();
      wait_idle();
      $display("sent %0d pixel and %0d drain transactions over %0d register writes",
               pixel_count, drain_count, write_count);
      $display("checked %0d results, %0d mismatches", result_count, mismatches);
      if (mismatches == 0 && expected_pixels.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #48_000_000;
      $display("timeout with %0d results outstanding", expected_pixels.size());
      $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

// ===== adaptive_mean_threshold_binarizer.f =====
+incdir+design
design/amtb_pkg.sv
design/amtb_ram.sv
design/amtb_front.sv
design/amtb_back.sv
design/adaptive_mean_threshold_binarizer.sv
design/amtb_checker.sv
tb/sv/tb.sv
